// ===== rtl/ctns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctns_pkg
// Types, constants and fixed-point helpers for the cable tension block.
// ----------------------------------------------------------------------------
package ctns_pkg;

	localparam int VAL_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_QW   = 32;
	localparam int DIV_LAT  = DIV_QW + 1;
	localparam int LATENCY  = 2 * DIV_LAT + 13;
	localparam int F_DLY    = DIV_LAT + 1;
	localparam int XI_DLY   = DIV_LAT + 9;
	localparam int SLK_DLY  = 2 * DIV_LAT + 9;

	localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_MASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_MASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CABLE_LENGTH = 2'd2;

	localparam logic [31:0] VEHICLE_MASS_RST = 32'd65536;
	localparam logic [31:0] PAYLOAD_MASS_RST = 32'd16384;
	localparam logic [31:0] CABLE_LENGTH_RST = 32'd65536;
	// 0.001 m in q16.16
	localparam logic [31:0] SLACK_EPS = 32'd66;

	typedef struct packed {
		logic signed [31:0] rel_pos_x;
		logic signed [31:0] rel_pos_y;
		logic signed [31:0] rel_pos_z;
		logic signed [31:0] rel_vel_x;
		logic signed [31:0] rel_vel_y;
		logic signed [31:0] rel_vel_z;
		logic signed [31:0] thrust_x;
		logic signed [31:0] thrust_y;
		logic signed [31:0] thrust_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] tension_x;
		logic signed [31:0] tension_y;
		logic signed [31:0] tension_z;
		logic               slack;
	} out_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	// exact product, scaled down by 2^16 toward zero
	function automatic logic signed [48:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [63:0] pr;
		logic signed [48:0] m;
		pr = 64'(mag32(a)) * 64'(mag32(b));
		m = $signed({1'b0, pr[63:16]});
		return (a[31] ^ b[31]) ? -m : m;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	function automatic logic [30:0] clampu(input logic [63:0] x);
		return (x > 64'h7fff_ffff) ? 31'h7fff_ffff : x[30:0];
	endfunction

	// signed, saturated result from a magnitude quotient
	function automatic logic signed [31:0] sat_div(input logic [31:0] q, input logic ovf,
			input logic neg, input logic zero);
		if (zero) begin
			return '0;
		end else if (neg) begin
			if (ovf || q > 32'h8000_0000) begin
				return 32'sh8000_0000;
			end
			return $signed(-q);
		end else if (ovf || q[31]) begin
			return 32'sh7fff_ffff;
		end
		return $signed(q);
	endfunction

endpackage

// ===== rtl/cable_tension_and_slack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cable_tension_and_slack
// Cable tension vector and slack flag for a suspended point mass.
// Accepts one item per cycle while the output is not stalled.
// The depth comes from 33-stage restoring dividers in series: six in parallel by cable length,
// then one by total mass. A stalled output freezes the whole pipeline in place.
// Reset clears all valid bits and loads the default masses and length.
// ----------------------------------------------------------------------------
module cable_tension_and_slack
	import ctns_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	logic [31:0] vehicle_mass_q, payload_mass_q, cable_length_q;
	logic [63:0] lim2_q;
	logic        lok_q;
	logic [32:0] msum_q;
	logic        en;
	logic        vld_s [1:LATENCY];

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vehicle_mass_q <= VEHICLE_MASS_RST;
			payload_mass_q <= PAYLOAD_MASS_RST;
			cable_length_q <= CABLE_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VEHICLE_MASS: vehicle_mass_q <= cfg_data;
				CFG_PAYLOAD_MASS: payload_mass_q <= cfg_data;
				CFG_CABLE_LENGTH: cable_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// derived constants, settle long before an item needs them
	always_ff @(posedge clk) begin
		lim2_q <= 64'(cable_length_q - SLACK_EPS) * 64'(cable_length_q - SLACK_EPS);
		lok_q  <= cable_length_q >= SLACK_EPS;
		msum_q <= {1'b0, vehicle_mass_q} + {1'b0, payload_mass_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LATENCY; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= LATENCY; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// input register
	in_t in_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
		end
	end

	logic signed [31:0] dv [0:5];
	always_comb begin
		dv[0] = in_s1.rel_pos_x;
		dv[1] = in_s1.rel_pos_y;
		dv[2] = in_s1.rel_pos_z;
		dv[3] = in_s1.rel_vel_x;
		dv[4] = in_s1.rel_vel_y;
		dv[5] = in_s1.rel_vel_z;
	end

	// slack path
	logic [63:0] sq_s2 [0:2];
	logic        slack_s3, slack_d;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(mag32(dv[i])) * 64'(mag32(dv[i]));
			end
			slack_s3 <= lok_q && ((sq_s2[0] + sq_s2[1] + sq_s2[2]) <= lim2_q);
		end
	end

	ctns_dly #(.W(1), .DEPTH(SLK_DLY)) u_slk_dly (
		.clk(clk), .en(en), .d(slack_s3), .q(slack_d)
	);

	// direction and rate, divided by cable length
	logic [DIV_QW-1:0] q1 [0:5];
	logic              ovf1 [0:5];
	logic              neg1 [0:5];
	for (genvar g = 0; g < 6; g++) begin : g_div1
		ctns_div #(.NW(VAL_W + 16), .DW(VAL_W), .QW(DIV_QW)) u_div (
			.clk(clk), .en(en),
			.num({mag32(dv[g]), 16'h0000}),
			.den(cable_length_q),
			.neg(dv[g][31]),
			.quo(q1[g]), .ovf(ovf1[g]), .neg_o(neg1[g])
		);
	end

	logic [95:0] f_d;
	ctns_dly #(.W(96), .DEPTH(F_DLY)) u_f_dly (
		.clk(clk), .en(en),
		.d({in_s1.thrust_x, in_s1.thrust_y, in_s1.thrust_z}),
		.q(f_d)
	);

	logic signed [31:0] xi_s35 [0:2];
	logic signed [31:0] xd_s35 [0:2];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				xi_s35[i] <= sat_div(q1[i], ovf1[i], neg1[i], cable_length_q == '0);
				xd_s35[i] <= sat_div(q1[i+3], ovf1[i+3], neg1[i+3], cable_length_q == '0);
			end
		end
	end

	// cross product terms and thrust projection
	logic signed [48:0] m_s36 [0:8];
	always_ff @(posedge clk) begin
		if (en) begin
			m_s36[0] <= mulq(xi_s35[1], xd_s35[2]);
			m_s36[1] <= mulq(xi_s35[2], xd_s35[1]);
			m_s36[2] <= mulq(xi_s35[2], xd_s35[0]);
			m_s36[3] <= mulq(xi_s35[0], xd_s35[2]);
			m_s36[4] <= mulq(xi_s35[0], xd_s35[1]);
			m_s36[5] <= mulq(xi_s35[1], xd_s35[0]);
			m_s36[6] <= mulq(xi_s35[0], $signed(f_d[95:64]));
			m_s36[7] <= mulq(xi_s35[1], $signed(f_d[63:32]));
			m_s36[8] <= mulq(xi_s35[2], $signed(f_d[31:0]));
		end
	end

	logic signed [31:0] w_s37 [0:2];
	logic signed [31:0] p_s37, p_s38, p_s39, p_s40, p_s41;
	logic [63:0]        wsq_s38 [0:2];
	logic [30:0]        c1_s39, c2_s40, c3_s41;
	logic [31:0]        smag_s42;
	logic               sneg_s42, sneg_s43;
	logic [63:0]        n2_s43;
	logic signed [63:0] sdiff;

	always_comb begin
		sdiff = $signed(64'(c3_s41)) - 64'(p_s41);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				w_s37[j] <= sat32(64'(m_s36[2*j]) - 64'(m_s36[2*j+1]));
				wsq_s38[j] <= 64'(mag32(w_s37[j])) * 64'(mag32(w_s37[j]));
			end
			p_s37 <= sat32(64'(m_s36[6]) + 64'(m_s36[7]) + 64'(m_s36[8]));
			p_s38 <= p_s37;
			c1_s39 <= clampu((wsq_s38[0] + wsq_s38[1] + wsq_s38[2]) >> 16);
			p_s39 <= p_s38;
			c2_s40 <= clampu((64'(c1_s39) * 64'(payload_mass_q)) >> 16);
			p_s40 <= p_s39;
			c3_s41 <= clampu((64'(c2_s40) * 64'(cable_length_q)) >> 16);
			p_s41 <= p_s40;
			smag_s42 <= mag32(sat32(sdiff));
			sneg_s42 <= sdiff[63];
			n2_s43 <= 64'(smag_s42) * 64'(payload_mass_q);
			sneg_s43 <= sneg_s42;
		end
	end

	// scale by payload share of total mass
	logic [DIV_QW-1:0] q2;
	logic              ovf2, neg2;
	ctns_div #(.NW(64), .DW(33), .QW(DIV_QW)) u_div2 (
		.clk(clk), .en(en),
		.num(n2_s43), .den(msum_q), .neg(sneg_s43),
		.quo(q2), .ovf(ovf2), .neg_o(neg2)
	);

	logic [95:0] xi_d;
	ctns_dly #(.W(96), .DEPTH(XI_DLY)) u_xi_dly (
		.clk(clk), .en(en),
		.d({xi_s35[0], xi_s35[1], xi_s35[2]}),
		.q(xi_d)
	);

	logic signed [31:0] k_s77;
	logic signed [48:0] tp_s78 [0:2];
	out_t               out_s79;
	always_ff @(posedge clk) begin
		if (en) begin
			k_s77 <= sat_div(q2, ovf2, neg2, msum_q == '0);
			tp_s78[0] <= mulq($signed(xi_d[95:64]), k_s77);
			tp_s78[1] <= mulq($signed(xi_d[63:32]), k_s77);
			tp_s78[2] <= mulq($signed(xi_d[31:0]), k_s77);
			out_s79.tension_x <= sat32(64'(tp_s78[0]));
			out_s79.tension_y <= sat32(64'(tp_s78[1]));
			out_s79.tension_z <= sat32(64'(tp_s78[2]));
			out_s79.slack <= slack_d;
		end
	end

	assign out_data  = out_s79;
	assign out_valid = vld_s[LATENCY];

endmodule

// ===== rtl/ctns_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctns_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
module ctns_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic          neg_o
);
	localparam int CW = (NW > DW) ? NW : DW;

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] lo_s  [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          ovf_s [0:QW];
	logic          neg_s [0:QW];

	// quotient overflows when the top part already holds the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DW'(num >> QW);
			lo_s[0]  <= num[QW-1:0];
			quo_s[0] <= '0;
			ovf_s[0] <= CW'(num >> QW) >= CW'(den);
			neg_s[0] <= neg;
		end
	end

	for (genvar g = 1; g <= QW; g++) begin : g_step
		logic [DW:0] trial;
		logic        fit;
		always_comb begin
			trial = {rem_s[g-1], lo_s[g-1][QW-1]};
			fit = trial >= {1'b0, den};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= fit ? DW'(trial - {1'b0, den}) : DW'(trial);
				lo_s[g]  <= lo_s[g-1] << 1;
				quo_s[g] <= {quo_s[g-1][QW-2:0], fit};
				ovf_s[g] <= ovf_s[g-1];
				neg_s[g] <= neg_s[g-1];
			end
		end
	end

	assign quo   = quo_s[QW];
	assign ovf   = ovf_s[QW];
	assign neg_o = neg_s[QW];

endmodule

// ===== rtl/ctns_dly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctns_dly
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module ctns_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

// ===== rtl/ctns_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctns_chk
// Port-level checks of the cable tension block, bound to the top level.
// ----------------------------------------------------------------------------
module ctns_chk
	import ctns_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);
	// the input is held back exactly when a finished item waits
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output backpressure");

	// while the output is stalled, it must stay valid and keep its slack flag
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data.slack)))
		else $error("pipeline moved while frozen");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled output item changed");

endmodule

bind cable_tension_and_slack ctns_chk u_ctns_chk (.*);
